FILE: sv/occ_pkg.sv
// Package: shared constants, codes and types of the obstacle collision checker.
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

	// Obstacle table size and derived widths
	localparam int OBSTACLES = 64;
	localparam int CNT_W     = $clog2(OBSTACLES + 1);
	localparam int CHAIN_LAT = 2 * OBSTACLES;
	localparam int FLY_W     = $clog2(CHAIN_LAT + 1);

	// Fixed field widths
	localparam int COORD_W  = 16;
	localparam int EXT_W    = 15;
	localparam int MARGIN_W = 8;
	localparam int SLOT_W   = 6;
	localparam int PT_W     = 18;   // sample coordinate, signed
	localparam int DD_W     = 34;   // squared segment length
	localparam int SQ_W     = 35;   // squared sample distance
	localparam int ROOT_W   = 25;   // length with 8 fraction bits
	localparam int RAD_W    = 50;   // radicand of the length root
	localparam int SREM_W   = 28;
	localparam int NUM_W    = 28;   // 4096 * |d|
	localparam int OFS_W    = 20;   // sample offset accumulator
	localparam int SQRT_ITERS = RAD_W / 2;
	localparam int DIV_ITERS  = NUM_W;
	localparam int ITER_W     = 5;

	// Item function codes
	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_POINT = 2'd1,
		FN_SEG   = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	// Configuration register indexes
	localparam logic [1:0] REG_MARGIN = 2'd0;
	localparam logic [1:0] REG_ACTIVE = 2'd1;

	// Obstacle shape codes
	localparam logic KIND_CIRCLE = 1'b0;
	localparam logic KIND_RECT   = 1'b1;

	// One obstacle table entry
	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [EXT_W-1:0]          w;
		logic [EXT_W-1:0]          h;
	} obs_t;

	// Probe point travelling down the cell row
	typedef struct packed {
		logic                   valid;
		logic signed [PT_W-1:0] px;
		logic signed [PT_W-1:0] py;
		logic                   hit;
	} probe_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POINT,
		ST_SQ,
		ST_SUM,
		ST_SQRT,
		ST_DIV,
		ST_STREAM,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: sv/occ_cell.sv
// One cell of the row: holds one obstacle and tests each passing probe against it.
`timescale 1ns / 1ps
`default_nettype none

module occ_cell
	import occ_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                we,
	input  wire obs_t                wdata,
	input  wire logic                en,
	input  wire logic [MARGIN_W-1:0] margin,
	input  wire probe_t              probe_in,
	output probe_t                   probe_out
);

	obs_t entry_q;

	logic                   valid_s1, hit_s1, rect_s1;
	logic signed [PT_W-1:0] px_s1, py_s1;
	logic signed [PT_W:0]   ddx_s1, ddy_s1;
	logic [COORD_W-1:0]     rr_s1;

	logic                      valid_s2, hit_s2, rect_s2;
	logic signed [PT_W-1:0]    px_s2, py_s2;
	logic signed [2*PT_W+1:0]  sqx_s2, sqy_s2;
	logic [2*COORD_W-1:0]      rr2_s2;

	logic signed [PT_W+1:0] pxe, pye, xlo, xhi, ylo, yhi;
	logic [2*PT_W+2:0]      dist2;
	logic                   circ_hit;

	// Store the obstacle on a load
	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= wdata;
		end
	end

	// Grown rectangle bounds and distance terms
	always_comb begin
		pxe = {{2{probe_in.px[PT_W-1]}}, probe_in.px};
		pye = {{2{probe_in.py[PT_W-1]}}, probe_in.py};
		xlo = {{4{entry_q.x[COORD_W-1]}}, entry_q.x} - {12'd0, margin};
		ylo = {{4{entry_q.y[COORD_W-1]}}, entry_q.y} - {12'd0, margin};
		xhi = {{4{entry_q.x[COORD_W-1]}}, entry_q.x} + {5'd0, entry_q.w} + {12'd0, margin};
		yhi = {{4{entry_q.y[COORD_W-1]}}, entry_q.y} + {5'd0, entry_q.h} + {12'd0, margin};
	end

	// Stage 1: differences and rectangle test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= probe_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= probe_in.px;
		py_s1   <= probe_in.py;
		hit_s1  <= probe_in.hit;
		ddx_s1  <= {probe_in.px[PT_W-1], probe_in.px} - {{3{entry_q.x[COORD_W-1]}}, entry_q.x};
		ddy_s1  <= {probe_in.py[PT_W-1], probe_in.py} - {{3{entry_q.y[COORD_W-1]}}, entry_q.y};
		rr_s1   <= {1'b0, entry_q.w} + {8'd0, margin};
		rect_s1 <= (pxe >= xlo) && (pxe <= xhi) && (pye >= ylo) && (pye <= yhi);
	end

	// Stage 2: squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		hit_s2  <= hit_s1;
		rect_s2 <= rect_s1;
		sqx_s2  <= ddx_s1 * ddx_s1;
		sqy_s2  <= ddy_s1 * ddy_s1;
		rr2_s2  <= rr_s1 * rr_s1;
	end

	// Compare and merge the hit into the probe
	always_comb begin
		dist2     = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		circ_hit  = dist2 <= {7'd0, rr2_s2};
		probe_out.valid = valid_s2;
		probe_out.px    = px_s2;
		probe_out.py    = py_s2;
		probe_out.hit   = hit_s2 |
			(en & ((entry_q.kind == KIND_RECT) ? rect_s2 : circ_hit));
	end

endmodule

`default_nettype wire

FILE: sv/obstacle_collision_check.sv
// Top level: item sequencer, segment sampler and the row of obstacle cells.
`timescale 1ns / 1ps
`default_nettype none

// Obstacle collision checker. Loads write one obstacle into its cell and return
// collided = 0 through the done state and the output register. Queries push
// probe points through a row of OBSTACLES cells, two register stages per cell.
// A segment query first takes the length root, then the step division for both
// axes; then one sample enters the row per cycle, one sample per 16 units of
// segment length, rounded up. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken.
module obstacle_collision_check
	import occ_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	// configuration
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	// input items
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// slot, ax, ay, bx, by, extent_w, extent_h, zero pad
	input  wire logic [103:0]  s_axis_tdata,
	// func, kind
	input  wire logic [2:0]    s_axis_tuser,
	// result items
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// collided, zero pad
	output logic [7:0]         m_axis_tdata
);

	state_t state_q, state_d;

	logic [MARGIN_W-1:0] margin_q;
	logic [CNT_W-1:0]    active_q;

	logic                       s_acc;
	func_t                      in_func;
	logic [SLOT_W-1:0]          in_slot;
	obs_t                       in_obs;
	logic signed [COORD_W-1:0]  in_bx, in_by;

	logic signed [COORD_W-1:0] ax_q, ay_q;
	logic signed [COORD_W:0]   dx_q, dy_q;
	logic [2*COORD_W+1:0]      sqx_q, sqy_q;
	logic [DD_W-1:0]           dd_q;
	logic [DD_W-1:0]           dd_sum;

	logic [RAD_W-1:0]  rad_q;
	logic [SREM_W-1:0] srem_q, spre, strial;
	logic [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0] iter_q;

	logic [NUM_W-1:0]  numx_q, numy_q, qx_q, qy_q;
	logic [ROOT_W-1:0] drx_q, dry_q;
	logic [ROOT_W:0]   dprex, dprey;

	logic [OFS_W-1:0]  ox_q, oy_q;
	logic [ROOT_W-1:0] rx_q, ry_q;
	logic [ROOT_W:0]   rx_n, ry_n;
	logic [SQ_W-1:0]   sq_q, inc_q;
	logic              more;

	logic [FLY_W-1:0] fly_q;
	logic             hit_acc_q;
	logic             out_valid_q, out_hit_q;
	logic             out_free;

	logic   inject, out_load;
	probe_t probe_src;

	probe_t         chain [OBSTACLES+1];
	logic [15:0]    abs_dx, abs_dy;

	// Unpack the item
	always_comb begin
		in_func     = func_t'(s_axis_tuser[1:0]);
		in_obs.kind = s_axis_tuser[2];
		in_slot     = s_axis_tdata[5:0];
		in_obs.x    = s_axis_tdata[21:6];
		in_obs.y    = s_axis_tdata[37:22];
		in_bx       = s_axis_tdata[53:38];
		in_by       = s_axis_tdata[69:54];
		in_obs.w    = s_axis_tdata[84:70];
		in_obs.h    = s_axis_tdata[99:85];
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid & s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= 8'd10;
			active_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MARGIN: margin_q <= cfg_data;
				REG_ACTIVE: active_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					unique case (in_func)
						FN_POINT: state_d = ST_POINT;
						FN_SEG:   state_d = ST_SQ;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_POINT:  state_d = ST_DRAIN;
			ST_SQ:     state_d = ST_SUM;
			ST_SUM:    state_d = (dd_sum == '0) ? ST_DONE : ST_SQRT;
			ST_SQRT:   if (iter_q == ITER_W'(SQRT_ITERS - 1)) state_d = ST_DIV;
			ST_DIV:    if (iter_q == ITER_W'(DIV_ITERS - 1)) state_d = ST_STREAM;
			ST_STREAM: if (!more) state_d = ST_DRAIN;
			ST_DRAIN:  if (fly_q == '0) state_d = ST_DONE;
			ST_DONE:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Outputs of the sequencer
	assign more = sq_q < {1'b0, dd_q};

	always_comb begin
		inject    = 1'b0;
		out_load  = 1'b0;
		probe_src.hit = 1'b0;
		probe_src.px  = {{2{ax_q[COORD_W-1]}}, ax_q};
		probe_src.py  = {{2{ay_q[COORD_W-1]}}, ay_q};
		unique case (state_q)
			ST_POINT:  inject = 1'b1;
			ST_STREAM: begin
				inject = more;
				probe_src.px = {{2{ax_q[COORD_W-1]}}, ax_q} +
					(dx_q[COORD_W] ? -PT_W'(ox_q) : PT_W'(ox_q));
				probe_src.py = {{2{ay_q[COORD_W-1]}}, ay_q} +
					(dy_q[COORD_W] ? -PT_W'(oy_q) : PT_W'(oy_q));
			end
			ST_DONE:   out_load = out_free;
			default: ;
		endcase
		probe_src.valid = inject;
	end

	// Capture the query
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ax_q <= in_obs.x;
			ay_q <= in_obs.y;
			dx_q <= {in_bx[COORD_W-1], in_bx} - {in_obs.x[COORD_W-1], in_obs.x};
			dy_q <= {in_by[COORD_W-1], in_by} - {in_obs.y[COORD_W-1], in_obs.y};
		end
	end

	// Squared length
	assign dd_sum = sqx_q + sqy_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_SQ) begin
			sqx_q <= dx_q * dx_q;
			sqy_q <= dy_q * dy_q;
		end
		if (state_q == ST_SUM) begin
			dd_q <= dd_sum;
		end
	end

	// Length root, two radicand bits a cycle
	assign spre   = {srem_q[SREM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign strial = {1'b0, root_q, 2'b01};

	// Step division, one quotient bit a cycle for both axes
	assign dprex = {drx_q, numx_q[NUM_W-1]};
	assign dprey = {dry_q, numy_q[NUM_W-1]};

	assign abs_dx = dx_q[COORD_W] ? 16'(-dx_q) : dx_q[15:0];
	assign abs_dy = dy_q[COORD_W] ? 16'(-dy_q) : dy_q[15:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SUM: begin
				rad_q  <= {dd_sum, 16'd0};
				srem_q <= '0;
				root_q <= '0;
				iter_q <= '0;
			end
			ST_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				iter_q <= (iter_q == ITER_W'(SQRT_ITERS - 1)) ? '0 : iter_q + 1'b1;
				if (spre >= strial) begin
					srem_q <= spre - strial;
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					srem_q <= spre;
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
				numx_q <= {abs_dx, 12'd0};
				numy_q <= {abs_dy, 12'd0};
				drx_q  <= '0;
				dry_q  <= '0;
			end
			ST_DIV: begin
				iter_q <= iter_q + 1'b1;
				numx_q <= {numx_q[NUM_W-2:0], 1'b0};
				numy_q <= {numy_q[NUM_W-2:0], 1'b0};
				if (dprex >= {1'b0, root_q}) begin
					drx_q <= ROOT_W'(dprex - {1'b0, root_q});
					qx_q  <= {qx_q[NUM_W-2:0], 1'b1};
				end else begin
					drx_q <= dprex[ROOT_W-1:0];
					qx_q  <= {qx_q[NUM_W-2:0], 1'b0};
				end
				if (dprey >= {1'b0, root_q}) begin
					dry_q <= ROOT_W'(dprey - {1'b0, root_q});
					qy_q  <= {qy_q[NUM_W-2:0], 1'b1};
				end else begin
					dry_q <= dprey[ROOT_W-1:0];
					qy_q  <= {qy_q[NUM_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Advance the sample offsets by quotient and remainder
	assign rx_n = {1'b0, rx_q} + {1'b0, drx_q};
	assign ry_n = {1'b0, ry_q} + {1'b0, dry_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			ox_q  <= '0;
			oy_q  <= '0;
			rx_q  <= '0;
			ry_q  <= '0;
			sq_q  <= '0;
			inc_q <= SQ_W'(256);
		end else if (state_q == ST_STREAM && more) begin
			sq_q  <= sq_q + inc_q;
			inc_q <= inc_q + SQ_W'(512);
			if (rx_n >= {1'b0, root_q}) begin
				rx_q <= ROOT_W'(rx_n - {1'b0, root_q});
				ox_q <= ox_q + qx_q[OFS_W-1:0] + 1'b1;
			end else begin
				rx_q <= rx_n[ROOT_W-1:0];
				ox_q <= ox_q + qx_q[OFS_W-1:0];
			end
			if (ry_n >= {1'b0, root_q}) begin
				ry_q <= ROOT_W'(ry_n - {1'b0, root_q});
				oy_q <= oy_q + qy_q[OFS_W-1:0] + 1'b1;
			end else begin
				ry_q <= ry_n[ROOT_W-1:0];
				oy_q <= oy_q + qy_q[OFS_W-1:0];
			end
		end
	end

	// Row of obstacle cells
	assign chain[0] = probe_src;

	for (genvar k = 0; k < OBSTACLES; k++) begin : g_cell
		logic we_k, en_k;
		assign we_k = s_acc && (in_func == FN_LOAD) && (32'(in_slot) == k);
		assign en_k = CNT_W'(k) < active_q;
		occ_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.we        (we_k),
			.wdata     (in_obs),
			.en        (en_k),
			.margin    (margin_q),
			.probe_in  (chain[k]),
			.probe_out (chain[k+1])
		);
	end

	// Count probes in the row and gather hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fly_q     <= '0;
			hit_acc_q <= 1'b0;
		end else begin
			fly_q <= fly_q + FLY_W'(inject) - FLY_W'(chain[OBSTACLES].valid);
			if (s_acc) begin
				hit_acc_q <= 1'b0;
			end else if (chain[OBSTACLES].valid && chain[OBSTACLES].hit) begin
				hit_acc_q <= 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_hit_q <= hit_acc_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_hit_q};

endmodule

`default_nettype wire

FILE: sv/occ_checker.sv
// Checker: port-level properties of the collision checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module occ_checker
	import occ_pkg::*;
(
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [2:0]   s_axis_tuser,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [7:0]   m_axis_tdata
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Hold a result until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped before it was taken");

	// One item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("item taken while another is in work");

	// A load into an empty output answers no hit
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_axis_tuser[1:0] == FN_LOAD) && !m_axis_tvalid |->
			##2 (m_axis_tvalid && !m_axis_tdata[0]))
		else $error("load result missing or nonzero");

	// Pad bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
		else $error("result pad bits set");

endmodule

bind obstacle_collision_check occ_checker u_occ_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: tb/sv/occ_scoreboard.sv
// Checker: predicts collision results from observed items and compares them.
`timescale 1ns / 1ps

module occ_scoreboard
	import occ_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire logic          s_axis_tvalid,
	input  wire logic          s_axis_tready,
	input  wire logic [103:0]  s_axis_tdata,
	input  wire logic [2:0]    s_axis_tuser,
	input  wire logic          m_axis_tvalid,
	input  wire logic          m_axis_tready,
	input  wire logic [7:0]    m_axis_tdata,
	output int                 errors,
	output int                 pending,
	output int                 hits
);

	// shadow of the obstacle table and registers
	logic         tab_kind [OBSTACLES];
	longint       tab_x [OBSTACLES];
	longint       tab_y [OBSTACLES];
	longint       tab_w [OBSTACLES];
	longint       tab_h [OBSTACLES];
	longint       clearance;
	int unsigned  active_cnt;
	bit           collided_q [$];

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd4294967296;
		// largest r with r*r <= v
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic bit point_collides(longint px, longint py);
		int unsigned n;
		longint ddx, ddy, rr;
		n = (active_cnt > OBSTACLES) ? OBSTACLES : active_cnt;
		for (int k = 0; k < n; k++) begin
			if (tab_kind[k] == KIND_CIRCLE) begin
				ddx = px - tab_x[k];
				ddy = py - tab_y[k];
				rr  = tab_w[k] + clearance;
				if (ddx * ddx + ddy * ddy <= rr * rr)
					return 1'b1;
			end else if (px >= tab_x[k] - clearance && px <= tab_x[k] + tab_w[k] + clearance &&
				py >= tab_y[k] - clearance && py <= tab_y[k] + tab_h[k] + clearance) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// offset of sample i along one axis, truncated toward zero
	function automatic longint step_offset(longint unsigned i, longint d, longint unsigned len8);
		longint unsigned q;
		q = (i * 4096 * longint'(d < 0 ? -d : d)) / len8;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit segment_collides(longint x0, longint y0, longint x1, longint y1);
		longint dx, dy;
		longint unsigned dd, len8, i;
		dx = x1 - x0;
		dy = y1 - y0;
		dd = dx * dx + dy * dy;
		if (dd == 0)
			return 1'b0;
		len8 = root_floor(dd << 16);
		for (i = 0; (16 * i) * (16 * i) < dd; i++)
			if (point_collides(x0 + step_offset(i, dx, len8), y0 + step_offset(i, dy, len8)))
				return 1'b1;
		return 1'b0;
	endfunction

	// track config writes, predict on input items, compare on result items
	always @(posedge clk or negedge arst_n) begin
		func_t   fn;
		logic    [5:0] slot;
		longint  ax, ay, bx, by;
		bit      hit, got;
		if (!arst_n) begin
			for (int k = 0; k < OBSTACLES; k++) begin
				tab_kind[k] = KIND_CIRCLE;
				tab_x[k] = 0; tab_y[k] = 0; tab_w[k] = 0; tab_h[k] = 0;
			end
			clearance  = 10;
			active_cnt = 0;
			collided_q.delete();
			errors  <= 0;
			pending <= 0;
			hits    <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MARGIN)
					clearance = cfg_data;
				else if (cfg_index == REG_ACTIVE)
					active_cnt = cfg_data[6:0];
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fn   = func_t'(s_axis_tuser[1:0]);
				slot = s_axis_tdata[5:0];
				ax   = $signed(s_axis_tdata[21:6]);
				ay   = $signed(s_axis_tdata[37:22]);
				bx   = $signed(s_axis_tdata[53:38]);
				by   = $signed(s_axis_tdata[69:54]);
				hit  = 1'b0;
				case (fn)
					FN_LOAD: begin
						tab_kind[slot] = s_axis_tuser[2];
						tab_x[slot] = ax;
						tab_y[slot] = ay;
						tab_w[slot] = s_axis_tdata[84:70];
						tab_h[slot] = s_axis_tdata[99:85];
					end
					FN_POINT: hit = point_collides(ax, ay);
					FN_SEG:   hit = segment_collides(ax, ay, bx, by);
					default:  hit = 1'b0;
				endcase
				collided_q = {collided_q, hit};
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[0];
				if (collided_q.size() == 0) begin
					$error("collided: unexpected result item, actual %0b", got);
					errors <= errors + 1;
				end else begin
					hit = collided_q.pop_front();
					if (got !== hit) begin
						$error("collided: expected %0b, actual %0b", hit, got);
						errors <= errors + 1;
					end
					if (hit)
						hits <= hits + 1;
				end
			end
			pending <= collided_q.size();
		end
	end

endmodule

FILE: tb/sv/obstacle_collision_check_tb.sv
// Testbench top: clock, reset, item stimulus, config phases and verdict.
`timescale 1ns / 1ps

module obstacle_collision_check_tb;
	import occ_pkg::*;

	localparam int IDLE_LIMIT = 40000;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [7:0]    cfg_data;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	// slot, ax, ay, bx, by, extent_w, extent_h, zero pad
	logic [103:0]  s_axis_tdata;
	// func, kind
	logic [2:0]    s_axis_tuser;
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	// collided, zero pad
	logic [7:0]    m_axis_tdata;

	int  errors, pending, hits;
	int  sent;
	int  received = 0;
	int  idle_cycles = 0;
	int  filled;       // slots 0..filled-1 hold a loaded obstacle
	bit  calm;         // stretch with no idling on either side
	bit  held;
	bit  filled_mask [OBSTACLES];

	obstacle_collision_check dut (.*);

	occ_scoreboard u_checker (.*);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			received <= received + 1;
	end

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 6);
			if (!held && received >= 150) begin
				held = 1'b1;
				gap = 400;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic send_item(func_t fn, logic [5:0] slot, logic kind,
		logic [15:0] ax, logic [15:0] ay, logic [15:0] bx, logic [15:0] by,
		logic [14:0] ew, logic [14:0] eh);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, eh, ew, by, bx, ay, ax, slot};
		s_axis_tuser  <= {kind, fn};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		calm = ((sent / 60) % 4) == 3;
		if (fn == FN_LOAD && slot == filled)
			while (filled < OBSTACLES && filled_mask[filled])
				filled++;
	endtask

	task automatic load_obstacle(logic [5:0] slot, logic kind, logic [15:0] x,
		logic [15:0] y, logic [14:0] w, logic [14:0] h);
		filled_mask[slot] = 1'b1;
		send_item(FN_LOAD, slot, kind, x, y, 16'($urandom), 16'($urandom), w, h);
	endtask

	// wait for the block to drain, then write one register
	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (12) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// coordinate mostly near the origin, sometimes anywhere
	function automatic logic [15:0] near_coord();
		if ($urandom_range(0, 15) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(0, 4000)) - 2000);
	endfunction

	function automatic logic [14:0] near_extent();
		if ($urandom_range(0, 15) == 0)
			return 15'($urandom);
		return 15'($urandom_range(0, 600));
	endfunction

	task automatic random_item();
		int sel;
		logic [15:0] ax, ay, bx, by;
		logic [5:0] slot;
		sel = $urandom_range(0, 99);
		ax = near_coord();
		ay = near_coord();
		if (sel < 30) begin
			// grow the loaded prefix or rewrite a loaded slot
			if (filled < OBSTACLES && ($urandom_range(0, 1) || filled == 0))
				slot = 6'(filled);
			else
				slot = 6'($urandom_range(0, filled - 1));
			load_obstacle(slot, 1'($urandom), ax, ay, near_extent(), near_extent());
		end else if (sel < 60) begin
			send_item(FN_POINT, 6'($urandom), 1'($urandom), ax, ay, 16'($urandom),
				16'($urandom), 15'($urandom), 15'($urandom));
		end else if (sel < 97) begin
			if ($urandom_range(0, 40) == 0) begin
				bx = 16'($urandom);
				by = 16'($urandom);
			end else begin
				bx = ax + 16'($signed($urandom_range(0, 1200)) - 600);
				by = ay + 16'($signed($urandom_range(0, 1200)) - 600);
			end
			send_item(FN_SEG, 6'($urandom), 1'($urandom), ax, ay, bx, by,
				15'($urandom), 15'($urandom));
		end else begin
			send_item(FN_NONE, 6'($urandom), 1'($urandom), ax, ay, 16'($urandom),
				16'($urandom), 15'($urandom), 15'($urandom));
		end
	endtask

	initial begin
		int act;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MARGIN;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		sent = 0; filled = 0; calm = 1'b0;
		foreach (filled_mask[k]) filled_mask[k] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: queries with no active obstacle, then extreme obstacles
		send_item(FN_POINT, '0, '0, 16'h0000, 16'h0000, '0, '0, '0, '0);
		send_item(FN_SEG, '0, '0, 16'h0000, 16'h0000, 16'h0100, 16'h0000, '0, '0);
		load_obstacle(6'd0, KIND_CIRCLE, 16'h0000, 16'h0000, 15'd0, 15'd0);
		load_obstacle(6'd1, KIND_RECT, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
		load_obstacle(6'd2, KIND_CIRCLE, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
		load_obstacle(6'd3, KIND_RECT, 16'd1000, 16'd1000, 15'd64, 15'd32);
		write_reg(REG_ACTIVE, 8'd4);
		write_reg(REG_MARGIN, 8'd0);
		send_item(FN_POINT, '0, '0, 16'h0000, 16'h0000, '0, '0, '0, '0);
		send_item(FN_POINT, '0, '0, 16'h0001, 16'h0000, '0, '0, '0, '0);
		send_item(FN_POINT, '0, '0, 16'h7fff, 16'h8000, '0, '0, '0, '0);
		send_item(FN_POINT, '0, '0, 16'd1064, 16'd1032, '0, '0, '0, '0);
		// zero length, endpoint on an obstacle, and an unused function code
		send_item(FN_SEG, '0, '0, 16'd500, 16'd500, 16'd500, 16'd500, '0, '0);
		send_item(FN_SEG, '0, '0, 16'hff00, 16'h0000, 16'h0000, 16'h0000, '0, '0);
		send_item(FN_SEG, '0, '0, 16'hff00, 16'h0000, 16'h0010, 16'h0000, '0, '0);
		send_item(FN_NONE, 6'h3f, 1'b1, 16'h0000, 16'h0000, 16'hffff, 16'hffff,
			15'h7fff, 15'h7fff);
		write_reg(REG_MARGIN, 8'd255);
		send_item(FN_POINT, '0, '0, 16'd1319, 16'd1000, '0, '0, '0, '0);
		send_item(FN_POINT, '0, '0, 16'h00ff, 16'h0000, '0, '0, '0, '0);
		send_item(FN_SEG, '0, '0, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, '0, '0);
		// unused register indexes are ignored
		write_reg(2'd2, 8'hff);
		write_reg(2'd3, 8'h00);

		// random phases under varied settings
		for (int phase = 0; phase < 8; phase++) begin
			if (phase >= 4)
				while (filled < OBSTACLES)
					load_obstacle(6'(filled), 1'($urandom), near_coord(), near_coord(),
						near_extent(), near_extent());
			case (phase)
				0, 1:    act = filled;
				4:       act = OBSTACLES;
				5:       act = 127;
				6:       act = 0;
				default: act = $urandom_range(0, filled);
			endcase
			write_reg(REG_ACTIVE, 8'(act));
			case (phase % 4)
				0: write_reg(REG_MARGIN, 8'd0);
				1: write_reg(REG_MARGIN, 8'd255);
				2: write_reg(REG_MARGIN, 8'd10);
				default: write_reg(REG_MARGIN, 8'($urandom));
			endcase
			repeat (72) random_item();
		end

		// drain and report
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (2 * OBSTACLES + 80) @(posedge clk);
		$display("Run covered %0d items over 8 config phases, %0d queries hit an obstacle.",
			sent, hits);
		$display("Obstacle table filled to %0d slots, %0d results checked.", filled, received);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
sv/occ_pkg.sv
sv/occ_cell.sv
sv/obstacle_collision_check.sv
sv/occ_checker.sv
tb/sv/occ_scoreboard.sv
tb/sv/obstacle_collision_check_tb.sv
